// ----- rtl/rv32i_eu_pkg.sv -----
// Package for the RV32I execute unit: opcodes, sizes and shared types.
// No dependencies.
`default_nettype none
package rv32i_eu_pkg;
  localparam int MemWords = 1024;
  localparam int MemAw = $clog2(MemWords);
  localparam int ByteAw = MemAw + 2;

  localparam logic [5:0] OP_LB = 6'd0, OP_LH = 6'd1, OP_LW = 6'd2, OP_LBU = 6'd3,
    OP_LHU = 6'd4, OP_SB = 6'd5, OP_SH = 6'd6, OP_SW = 6'd7, OP_ADD = 6'd8,
    OP_SUB = 6'd9, OP_SLL = 6'd10, OP_SLT = 6'd11, OP_SLTU = 6'd12, OP_XOR = 6'd13,
    OP_SRL = 6'd14, OP_SRA = 6'd15, OP_OR = 6'd16, OP_AND = 6'd17, OP_ADDI = 6'd18,
    OP_SLTI = 6'd19, OP_SLTIU = 6'd20, OP_XORI = 6'd21, OP_ORI = 6'd22,
    OP_ANDI = 6'd23, OP_SLLI = 6'd24, OP_SRLI = 6'd25, OP_SRAI = 6'd26,
    OP_BEQ = 6'd27, OP_BNE = 6'd28, OP_BGE = 6'd29, OP_BLTU = 6'd30,
    OP_BGEU = 6'd31, OP_JAL = 6'd32, OP_JALR = 6'd33, OP_LUI = 6'd34,
    OP_AUIPC = 6'd35;

  localparam logic [0:0] REG_START_PC = 1'd0;

  // classified instruction handed from front to back
  typedef struct packed {
    logic [5:0]  op;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic [31:0] target;
    logic        is_mem;
  } instr_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        write_valid;
    logic [4:0]  write_reg;
    logic [31:0] write_value;
    logic        fault;
  } result_t;
endpackage
`default_nettype wire

// ----- rtl/rv32i_eu_if.sv -----
// Valid/ready channel interfaces for the execute unit.
// No dependencies.
`default_nettype none
interface rv32i_eu_req_if;
  logic        valid;
  logic        ready;
  logic [5:0]  req_type;
  logic [4:0]  dest_reg;
  logic [4:0]  src1_reg;
  logic [4:0]  src2_reg;
  logic signed [31:0] immediate;
  logic [31:0] branch_target;
  modport source (output valid, req_type, dest_reg, src1_reg, src2_reg, immediate,
                  branch_target, input ready);
  modport sink (input valid, req_type, dest_reg, src1_reg, src2_reg, immediate,
                branch_target, output ready);
endinterface

interface rv32i_eu_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        write_valid;
  logic [4:0]  write_reg;
  logic [31:0] write_value;
  logic        fault;
  modport source (output valid, next_pc, write_valid, write_reg, write_value, fault,
                  input ready);
  modport sink (input valid, next_pc, write_valid, write_reg, write_value, fault,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/rv32i_eu_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module rv32i_eu_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- rtl/rv32i_eu_front.sv -----
// Front end: accepts instructions and tags memory operations into a 2-entry queue.
// Depends on rv32i_eu_pkg.
`default_nettype none
module rv32i_eu_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire rv32i_eu_pkg::instr_t in_instr,
  output logic      q_valid,
  input  wire logic q_pop,
  output rv32i_eu_pkg::instr_t q_instr
);
  import rv32i_eu_pkg::*;
  instr_t slot [2];
  instr_t in_tag;
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic push;

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign q_instr = slot[rd_ptr];

  always_comb begin
    in_tag = in_instr;
    in_tag.is_mem = (in_instr.op <= OP_SW);
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_tag;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/rv32i_eu_back.sv -----
// Back end: register file, PC, data memory and ALU; two-stage for memory ops.
// Depends on rv32i_eu_pkg and rv32i_eu_ram.
`default_nettype none
module rv32i_eu_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  wire rv32i_eu_pkg::instr_t q_instr,
  output logic             out_valid,
  input  wire logic        out_ready,
  output rv32i_eu_pkg::result_t out_res
);
  import rv32i_eu_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0, ST_RUN = 2'd1, ST_MEM = 2'd2;

  logic [1:0] state;
  logic [MemAw-1:0] clr_addr;
  logic [31:0] regs [32];
  logic [31:0] pc;

  logic [31:0] a, b, imm, sum_ai, alu, npc;
  logic wr, fault;
  logic [ByteAw-1:0] addr_lo;
  logic in_range;
  logic [31:0] pc4;

  // held memory op
  instr_t m_instr;
  instr_t m_load;
  logic [1:0] m_off;
  logic [31:0] m_b;

  logic ram_we;
  logic [MemAw-1:0] ram_addr;
  logic [31:0] ram_wdata, ram_rdata;
  logic [31:0] ld_val, st_word;
  logic [4:0] bsh, hsh;

  logic slot_free;
  result_t res_next;
  logic res_load;

  assign a = (q_instr.rs1 == 5'd0) ? 32'd0 : regs[q_instr.rs1];
  assign b = (q_instr.rs2 == 5'd0) ? 32'd0 : regs[q_instr.rs2];
  assign imm = q_instr.imm;
  assign sum_ai = a + imm;
  assign pc4 = pc + 32'd4;
  assign in_range = (sum_ai[31:ByteAw] == '0);
  assign addr_lo = sum_ai[ByteAw-1:0];
  assign slot_free = !out_valid || out_ready;

  // non-memory instruction
  always_comb begin
    alu = 32'd0;
    wr = 1'b1;
    npc = pc4;
    unique case (q_instr.op)
      OP_ADD:   alu = a + b;
      OP_SUB:   alu = a - b;
      OP_SLL:   alu = a << b[4:0];
      OP_SLT:   alu = {31'd0, $signed(a) < $signed(b)};
      OP_SLTU:  alu = {31'd0, a < b};
      OP_XOR:   alu = a ^ b;
      OP_SRL:   alu = a >> b[4:0];
      OP_SRA:   alu = 32'($signed(a) >>> b[4:0]);
      OP_OR:    alu = a | b;
      OP_AND:   alu = a & b;
      OP_ADDI:  alu = sum_ai;
      OP_SLTI:  alu = {31'd0, $signed(a) < $signed(imm)};
      OP_SLTIU: alu = {31'd0, a < imm};
      OP_XORI:  alu = a ^ imm;
      OP_ORI:   alu = a | imm;
      OP_ANDI:  alu = a & imm;
      OP_SLLI:  alu = a << imm[4:0];
      OP_SRLI:  alu = a >> imm[4:0];
      OP_SRAI:  alu = 32'($signed(a) >>> imm[4:0]);
      OP_BEQ:  begin wr = 1'b0; if (a == b) npc = q_instr.target; end
      OP_BNE:  begin wr = 1'b0; if (a != b) npc = q_instr.target; end
      OP_BGE:  begin wr = 1'b0; if (!($signed(a) < $signed(b))) npc = q_instr.target; end
      OP_BLTU: begin wr = 1'b0; if (a < b) npc = q_instr.target; end
      OP_BGEU: begin wr = 1'b0; if (a >= b) npc = q_instr.target; end
      OP_JAL:  begin alu = pc4; npc = q_instr.target; end
      OP_JALR: begin alu = pc4; npc = {sum_ai[31:1], 1'b0}; end
      OP_LUI:   alu = {imm[19:0], 12'd0};
      OP_AUIPC: alu = pc + {imm[19:0], 12'd0};
      default:  wr = 1'b0;
    endcase
    if (q_instr.rd == 5'd0) wr = 1'b0;
  end

  assign bsh = {m_off, 3'd0};
  assign hsh = {m_off[1], 4'd0};

  always_comb begin
    ld_val = 32'd0;
    st_word = ram_rdata;
    case (m_instr.op)
      OP_LB:  ld_val = {{24{ram_rdata[bsh+7]}}, 8'(ram_rdata >> bsh)};
      OP_LH:  ld_val = {{16{ram_rdata[hsh+15]}}, 16'(ram_rdata >> hsh)};
      OP_LW:  ld_val = ram_rdata;
      OP_LBU: ld_val = {24'd0, 8'(ram_rdata >> bsh)};
      OP_LHU: ld_val = {16'd0, 16'(ram_rdata >> hsh)};
      OP_SB:  st_word = (ram_rdata & ~(32'hFF << bsh)) | ({24'd0, m_b[7:0]} << bsh);
      OP_SH:  st_word = (ram_rdata & ~(32'hFFFF << hsh)) | ({16'd0, m_b[15:0]} << hsh);
      default: st_word = m_b;
    endcase
  end

  // keep word index in the immediate field for the ST_MEM access (load hold and store write-back)
  always_comb begin
    m_load = q_instr;
    m_load.imm = {{(32-MemAw){1'b0}}, addr_lo[ByteAw-1:2]};
  end

  // RAM port: clear sweep, write-back of stores in ST_MEM, else read address
  always_comb begin
    ram_we = 1'b0;
    ram_addr = addr_lo[ByteAw-1:2];
    ram_wdata = st_word;
    q_pop = 1'b0;
    res_load = 1'b0;
    res_next = '0;
    fault = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_addr;
        ram_wdata = 32'd0;
      end
      ST_MEM: begin
        // hold the read address so the loaded word survives a stall
        ram_addr = m_instr.imm[MemAw-1:0];
        if (slot_free) begin
          res_load = 1'b1;
          res_next.next_pc = pc4;
          if (m_instr.op >= OP_SB) begin
            ram_we = 1'b1;
          end else if (m_instr.rd != 5'd0) begin
            res_next.write_valid = 1'b1;
            res_next.write_reg = m_instr.rd;
            res_next.write_value = ld_val;
          end
        end
      end
      default: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          if (q_instr.is_mem) begin
            fault = !in_range;
            if (fault) begin
              res_load = 1'b1;
              res_next.next_pc = pc;
              res_next.fault = 1'b1;
            end
          end else begin
            res_load = 1'b1;
            res_next.next_pc = npc;
            res_next.write_valid = wr;
            res_next.write_reg = wr ? q_instr.rd : 5'd0;
            res_next.write_value = wr ? alu : 32'd0;
          end
        end
      end
    endcase
  end

  rv32i_eu_ram #(.Width(32), .Depth(MemWords)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (res_load) out_res <= res_next;
    if (state == ST_RUN && q_pop && q_instr.is_mem && in_range) begin
      m_instr <= m_load;
      m_off <= addr_lo[1:0];
      m_b <= b;
    end
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
      pc <= 32'd0;
      for (int i = 0; i < 32; i++) regs[i] <= 32'd0;
    end else begin
      if (res_load && res_next.write_valid) regs[res_next.write_reg] <= res_next.write_value;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) pc <= cfg_data;
      else if (res_load) pc <= res_next.next_pc;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == MemAw'(MemWords - 1)) state <= ST_RUN;
        end
        ST_RUN: if (q_pop && q_instr.is_mem && in_range) state <= ST_MEM;
        ST_MEM: if (slot_free) state <= ST_RUN;
        default: state <= ST_RUN;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/rv32i_execute_unit_core.sv -----
// RV32I execute unit top level: APB config port, request and result channels.
// Depends on rv32i_eu_pkg, the channel interfaces, front and back ends.
//
// Usage: drive decoded instructions on req (valid/ready); each produces exactly
// one transfer on rsp with next PC, register write and fault flag. start_pc is
// written through APB at address 0 and also loads the PC; the user must write
// it only while idle; the block itself does not enforce this. Loads and stores
// take an extra ST_MEM state in the back end because the data memory read is
// registered. Each input passes through the 2-entry queue and the result
// register. After reset the back end sweeps the 1024-word data memory to zero,
// during which results are not produced; the queue still takes up to two items.
// When rsp is stalled the result register holds and the queue fills, then req
// ready drops.
`default_nettype none
module rv32i_execute_unit_core (
  input  wire logic        clk,
  input  wire logic        rst,
  rv32i_eu_req_if.sink     req,
  rv32i_eu_rsp_if.source   rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import rv32i_eu_pkg::*;
  instr_t in_instr, q_instr;
  logic q_valid, q_pop, cfg_we;
  logic [31:0] start_pc;
  result_t res;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[1:0] == 2'd0) && (REG_START_PC == 1'b0);
  assign prdata = (paddr == 2'd0) ? start_pc : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) start_pc <= 32'd0;
    else if (cfg_we) start_pc <= pwdata;
  end

  always_comb begin
    in_instr.op = req.req_type;
    in_instr.rd = req.dest_reg;
    in_instr.rs1 = req.src1_reg;
    in_instr.rs2 = req.src2_reg;
    in_instr.imm = req.immediate;
    in_instr.target = req.branch_target;
    in_instr.is_mem = 1'b0;
  end

  rv32i_eu_front u_front (
    .clk(clk), .rst(rst), .in_valid(req.valid), .in_ready(req.ready),
    .in_instr(in_instr), .q_valid(q_valid), .q_pop(q_pop), .q_instr(q_instr)
  );

  rv32i_eu_back u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(pwdata),
    .q_valid(q_valid), .q_pop(q_pop), .q_instr(q_instr),
    .out_valid(rsp.valid), .out_ready(rsp.ready), .out_res(res)
  );

  assign rsp.next_pc = res.next_pc;
  assign rsp.write_valid = res.write_valid;
  assign rsp.write_reg = res.write_reg;
  assign rsp.write_value = res.write_value;
  assign rsp.fault = res.fault;
endmodule
`default_nettype wire

// ----- rtl/rv32i_eu_checker.sv -----
// Port-level checker for the execute unit, bound to the top level.
// Depends on the top level's port names only.
`default_nettype none
module rv32i_eu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic        rsp_write_valid,
  input wire logic [4:0]  rsp_write_reg,
  input wire logic [31:0] rsp_write_value,
  input wire logic        rsp_fault,
  input wire logic        pready
);
  a_x0: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_write_valid && rsp_write_reg == 5'd0)) else $error("x0 written");
  a_fault: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_fault |-> !rsp_write_valid) else $error("fault with write");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_write_valid |-> rsp_write_value == 32'd0) else $error("stray value");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind rv32i_execute_unit_core rv32i_eu_checker u_checker (
  .clk(clk), .rst(rst), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_write_valid(rsp.write_valid), .rsp_write_reg(rsp.write_reg),
  .rsp_write_value(rsp.write_value), .rsp_fault(rsp.fault), .pready(pready)
);
`default_nettype wire

// ----- tb/tb_rv32i_eu_sb.sv -----
// Scoreboard for the RV32I execute unit testbench: tracks architectural state
// and queues predicted results. Depends on rv32i_eu_pkg.
`default_nettype none
package tb_rv32i_eu_sb_pkg;
  import rv32i_eu_pkg::*;

  typedef struct packed {
    logic [5:0]  op;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic [31:0] target;
  } instr_fields_t;

  class eu_scoreboard;
    logic [31:0] regs [32];
    logic [31:0] mem [MemWords];
    logic [31:0] pc;
    logic [31:0] start_pc;
    result_t     pending_results[$];
    int          mismatches;
    int          checked;

    function new();
      start_pc = '0;
      reset_state();
      mismatches = 0;
      checked = 0;
    endfunction

    function void reset_state();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      pc = start_pc;
    endfunction

    function void load_start_pc(logic [31:0] v);
      start_pc = v;
      pc = v;
    endfunction

    function logic [31:0] rdreg(logic [4:0] i);
      return (i == 0) ? 32'd0 : regs[i];
    endfunction

    // execute one instruction on the shadow state and queue its result
    function void note_instr(instr_fields_t t);
      logic [31:0] a, b, npc, val, addr, w;
      logic [4:0]  bsh, hsh;
      logic        wr, flt;
      int unsigned wi;
      result_t     exp_res;
      a = rdreg(t.rs1);
      b = rdreg(t.rs2);
      npc = pc + 32'd4;
      val = '0;
      wr = 1'b0;
      flt = 1'b0;
      if (t.op <= OP_SW) begin
        addr = a + t.imm;
        if (addr >= 32'(MemWords * 4)) begin
          flt = 1'b1;
        end else begin
          wi = addr[31:2];
          w = mem[wi];
          bsh = {addr[1:0], 3'b000};
          hsh = {addr[1], 4'b0000};
          case (t.op)
            OP_LB:  begin val = {{24{w[bsh+7]}}, 8'(w >> bsh)}; wr = 1; end
            OP_LH:  begin val = {{16{w[hsh+15]}}, 16'(w >> hsh)}; wr = 1; end
            OP_LW:  begin val = w; wr = 1; end
            OP_LBU: begin val = 32'(8'(w >> bsh)); wr = 1; end
            OP_LHU: begin val = 32'(16'(w >> hsh)); wr = 1; end
            OP_SB:  mem[wi] = (w & ~(32'hFF << bsh)) | ((b & 32'hFF) << bsh);
            OP_SH:  mem[wi] = (w & ~(32'hFFFF << hsh)) | ((b & 32'hFFFF) << hsh);
            default: mem[wi] = b;
          endcase
        end
      end else begin
        wr = 1'b1;
        case (t.op)
          OP_ADD:   val = a + b;
          OP_SUB:   val = a - b;
          OP_SLL:   val = a << b[4:0];
          OP_SLT:   val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
          OP_SLTU:  val = (a < b) ? 32'd1 : 32'd0;
          OP_XOR:   val = a ^ b;
          OP_SRL:   val = a >> b[4:0];
          OP_SRA:   val = $signed(a) >>> b[4:0];
          OP_OR:    val = a | b;
          OP_AND:   val = a & b;
          OP_ADDI:  val = a + t.imm;
          OP_SLTI:  val = ($signed(a) < $signed(t.imm)) ? 32'd1 : 32'd0;
          OP_SLTIU: val = (a < t.imm) ? 32'd1 : 32'd0;
          OP_XORI:  val = a ^ t.imm;
          OP_ORI:   val = a | t.imm;
          OP_ANDI:  val = a & t.imm;
          OP_SLLI:  val = a << t.imm[4:0];
          OP_SRLI:  val = a >> t.imm[4:0];
          OP_SRAI:  val = $signed(a) >>> t.imm[4:0];
          OP_BEQ:   begin wr = 0; if (a == b) npc = t.target; end
          OP_BNE:   begin wr = 0; if (a != b) npc = t.target; end
          OP_BGE:   begin wr = 0; if (!($signed(a) < $signed(b))) npc = t.target; end
          OP_BLTU:  begin wr = 0; if (a < b) npc = t.target; end
          OP_BGEU:  begin wr = 0; if (a >= b) npc = t.target; end
          OP_JAL:   begin val = pc + 32'd4; npc = t.target; end
          OP_JALR:  begin val = pc + 32'd4; npc = (a + t.imm) & ~32'd1; end
          OP_LUI:   val = t.imm << 12;
          OP_AUIPC: val = pc + (t.imm << 12);
          default:  wr = 0;
        endcase
      end
      if (flt) begin
        npc = pc;
        wr = 1'b0;
      end
      if (t.rd == 0) wr = 1'b0;
      if (wr) regs[t.rd] = val;
      else val = '0;
      pc = npc;
      exp_res = '{next_pc: npc, write_valid: wr, write_reg: wr ? t.rd : 5'd0,
                  write_value: val, fault: flt};
      pending_results.insert(pending_results.size(), exp_res);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch %s: got %h want %h (result %0d)", what, got, want, checked);
    endtask

    task check_result(result_t r);
      result_t e;
      if (pending_results.size() == 0) begin
        report("unexpected result next_pc", r.next_pc, 32'd0);
        return;
      end
      e = pending_results.pop_front();
      if (r.next_pc !== e.next_pc) report("next_pc", r.next_pc, e.next_pc);
      if (r.write_valid !== e.write_valid)
        report("write_valid", 32'(r.write_valid), 32'(e.write_valid));
      if (r.write_reg !== e.write_reg)
        report("write_reg", 32'(r.write_reg), 32'(e.write_reg));
      if (r.write_value !== e.write_value) report("write_value", r.write_value, e.write_value);
      if (r.fault !== e.fault) report("fault", 32'(r.fault), 32'(e.fault));
      checked++;
    endtask
  endclass
endpackage
`default_nettype wire

// ----- tb/tb_rv32i_execute_unit_core.sv -----
// Top-level testbench for rv32i_execute_unit_core: directed and random
// instruction streams, APB start_pc writes, stall bursts and a long hold-off.
// Depends on rv32i_eu_pkg, the channel interfaces and tb_rv32i_eu_sb_pkg.
`default_nettype none
module tb_rv32i_execute_unit_core;
  timeunit 1ns;
  timeprecision 1ps;
  import rv32i_eu_pkg::*;
  import tb_rv32i_eu_sb_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int HoldOffCycles = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rv32i_eu_req_if req ();
  rv32i_eu_rsp_if rsp ();

  rv32i_execute_unit_core u_dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  eu_scoreboard sb = new();
  bit  sink_idle_on = 1'b1;
  bit  hold_off = 1'b0;
  bit  timed_out = 1'b0;
  int  quiet_cycles = 0;
  int  sent = 0;
  int  pc_settings = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.req_type = '0;
    req.dest_reg = '0;
    req.src1_reg = '0;
    req.src2_reg = '0;
    req.immediate = '0;
    req.branch_target = '0;
    rsp.ready = 1'b0;
  end

  // result side: check each accepted result; sink_proc drives random stall bursts and an optional long hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready)
        sb.check_result('{next_pc: rsp.next_pc, write_valid: rsp.write_valid,
                          write_reg: rsp.write_reg, write_value: rsp.write_value,
                          fault: rsp.fault});
    end
  end

  initial begin : sink_proc
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        rsp.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        hold_off = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        rsp.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired, %0d results outstanding", sb.pending_results.size());
      $display("[rv32i_execute_unit_core] ERROR");
      $finish;
    end
  end

  task automatic send_instr(instr_fields_t t, bit gaps);
    int n;
    if (gaps && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 17);
      req.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= t.op;
    req.dest_reg <= t.rd;
    req.src1_reg <= t.rs1;
    req.src2_reg <= t.rs2;
    req.immediate <= t.imm;
    req.branch_target <= t.target;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_instr(t);
    sent++;
  endtask

  task automatic release_valid();
    req.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    release_valid();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_start_pc(logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_START_PC, 1'b0};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.load_start_pc(v);
    pc_settings++;
  endtask

  function automatic instr_fields_t mk(logic [5:0] op, logic [4:0] rd, logic [4:0] rs1,
                                       logic [4:0] rs2, logic [31:0] imm,
                                       logic [31:0] target);
    return '{op: op, rd: rd, rs1: rs1, rs2: rs2, imm: imm, target: target};
  endfunction

  // mostly valid memory offsets off x0 as base; some wild
  function automatic instr_fields_t rand_instr();
    instr_fields_t t;
    t.op = $urandom_range(0, 9) == 0 ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 35));
    t.rd = 5'($urandom_range(0, 31));
    t.rs1 = 5'($urandom_range(0, 31));
    t.rs2 = 5'($urandom_range(0, 31));
    t.target = $urandom();
    case ($urandom_range(0, 3))
      0: t.imm = $urandom();
      1: t.imm = 32'($signed(12'($urandom())));
      default: t.imm = 32'($urandom_range(0, MemWords * 4 - 1));
    endcase
    if (t.op <= OP_SW && $urandom_range(0, 3) != 0) begin
      t.rs1 = 5'd0;
      t.imm = 32'($urandom_range(0, MemWords * 4 + 16));
    end
    if (t.op == OP_ADDI && $urandom_range(0, 1)) t.imm = 32'($urandom_range(0, 64));
    return t;
  endfunction

  initial begin : main
    instr_fields_t t;
    logic [5:0] op;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every operation, faults, x0, misalignment
    send_instr(mk(OP_LUI, 5'd1, 5'd0, 5'd0, 32'hFFFFF, 32'd0), 0);
    send_instr(mk(OP_ADDI, 5'd2, 5'd0, 5'd0, 32'hFFFFFFFF, 32'd0), 0);
    send_instr(mk(OP_ADDI, 5'd3, 5'd0, 5'd0, 32'h7FFFFFFF, 32'd0), 0);
    send_instr(mk(OP_ADDI, 5'd4, 5'd0, 5'd0, 32'h80000000, 32'd0), 0);
    send_instr(mk(OP_SW, 5'd0, 5'd0, 5'd2, 32'd13, 32'd0), 0);
    send_instr(mk(OP_SB, 5'd0, 5'd0, 5'd3, 32'd5, 32'd0), 0);
    send_instr(mk(OP_SH, 5'd0, 5'd0, 5'd4, 32'd7, 32'd0), 0);
    send_instr(mk(OP_LB, 5'd5, 5'd0, 5'd0, 32'd15, 32'd0), 0);
    send_instr(mk(OP_LBU, 5'd6, 5'd0, 5'd0, 32'd5, 32'd0), 0);
    send_instr(mk(OP_LH, 5'd7, 5'd0, 5'd0, 32'd5, 32'd0), 0);
    send_instr(mk(OP_LHU, 5'd8, 5'd0, 5'd0, 32'd14, 32'd0), 0);
    send_instr(mk(OP_LW, 5'd0, 5'd0, 5'd0, 32'd4, 32'd0), 0);
    send_instr(mk(OP_LW, 5'd9, 5'd0, 5'd0, 32'(MemWords * 4), 32'd0), 0);
    send_instr(mk(OP_SW, 5'd0, 5'd2, 5'd2, 32'd0, 32'd0), 0);
    send_instr(mk(OP_SRA, 5'd10, 5'd4, 5'd2, 32'd0, 32'd0), 0);
    send_instr(mk(OP_SRAI, 5'd11, 5'd4, 5'd0, 32'd33, 32'd0), 0);
    send_instr(mk(OP_SLT, 5'd12, 5'd4, 5'd3, 32'd0, 32'd0), 0);
    send_instr(mk(OP_SLTU, 5'd13, 5'd4, 5'd3, 32'd0, 32'd0), 0);
    send_instr(mk(OP_ADD, 5'd0, 5'd3, 5'd3, 32'd0, 32'd0), 0);
    send_instr(mk(OP_JALR, 5'd1, 5'd1, 5'd0, 32'd3, 32'd0), 0);
    send_instr(mk(OP_JAL, 5'd14, 5'd0, 5'd0, 32'd0, 32'hFFFFFFFC), 0);
    send_instr(mk(OP_AUIPC, 5'd15, 5'd0, 5'd0, 32'hFFFFF, 32'd0), 0);
    send_instr(mk(6'd63, 5'd16, 5'd0, 5'd0, 32'd0, 32'd0), 0);
    for (int k = 0; k < 36; k++) begin
      op = 6'(k);
      send_instr(mk(op, 5'($urandom_range(1, 31)), 5'($urandom_range(0, 31)),
                    5'($urandom_range(0, 31)), 32'($urandom_range(0, 64)), $urandom()), 1);
    end
    drain();

    // random phases across several start_pc settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_start_pc(32'hFFFFFFF8);
        1: write_start_pc(32'h0000_1000);
        2: write_start_pc(32'hFFFFFFFF);
        default: write_start_pc(32'h0);
      endcase
      if (ph == 1) hold_off = 1'b1;
      if (ph == 3) sink_idle_on = 1'b0;
      for (int i = 0; i < 440; i++) begin
        t = rand_instr();
        send_instr(t, ph != 3);
      end
      drain();
    end

    $display("ran %0d instructions over %0d start_pc settings, %0d results checked",
             sent, pc_settings, sb.checked);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("[rv32i_execute_unit_core] OK");
    end else begin
      $display("[rv32i_execute_unit_core] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/rv32i_eu_pkg.sv
rtl/rv32i_eu_if.sv
rtl/rv32i_eu_ram.sv
rtl/rv32i_eu_front.sv
rtl/rv32i_eu_back.sv
rtl/rv32i_execute_unit_core.sv
rtl/rv32i_eu_checker.sv
tb/tb_rv32i_eu_sb.sv
tb/tb_rv32i_execute_unit_core.sv
